// ===== rtl/vchf_pkg.sv =====
// Shared types, sizes, request codes and extension helpers for the veto
// coincidence hit filter. Depends on nothing; vchf_window_cmp and the core use it.
`default_nettype none

package vchf_pkg;

   // Store and field sizes
   localparam int VETO_DEPTH = 64;
   localparam int TIME_BITS  = 48;
   localparam int HIT_BITS   = 48;
   localparam int WIN_BITS   = 41;

   localparam int STORE_BITS = (TIME_BITS < HIT_BITS) ? TIME_BITS : HIT_BITS;
   localparam int ADDR_BITS  = (VETO_DEPTH > 1) ? $clog2(VETO_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(VETO_DEPTH + 1);
   localparam int CMP_BITS   = ((STORE_BITS > WIN_BITS) ? STORE_BITS : WIN_BITS) + 2;

   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(VETO_DEPTH);

   // Window register reset values (+/-2000 ns at 25 ps per tick)
   localparam logic [WIN_BITS-1:0] WINDOW_LOW_RESET  = WIN_BITS'(-80000);
   localparam logic [WIN_BITS-1:0] WINDOW_HIGH_RESET = WIN_BITS'(80000);

   // Request codes
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_TEST  = 2'd2;

   // Register indexes
   localparam logic CSR_WINDOW_LOW  = 1'b0;
   localparam logic CSR_WINDOW_HIGH = 1'b1;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [HIT_BITS-1:0] hit_time;
   } req_payload_type;

   typedef struct packed {
      logic                keep_hit;
      logic [HIT_BITS-1:0] target_time;
      logic                store_overflow;
   } rsp_payload_type;

   // Window compare outcome for one stored veto time
   typedef struct packed {
      logic below_low;
      logic in_window;
   } cmp_flags_type;

   // Zero-extend a stored time to the output field width
   function automatic logic [HIT_BITS-1:0] widen_time(input logic [STORE_BITS-1:0] t);
      logic [HIT_BITS-1:0] res;
      res = '0;
      res[STORE_BITS-1:0] = t;
      return res;
   endfunction

   // Zero-extend an unsigned value into the compare width
   function automatic logic signed [CMP_BITS-1:0] ext_time(input logic [STORE_BITS-1:0] t);
      logic signed [CMP_BITS-1:0] res;
      res = '0;
      res[STORE_BITS-1:0] = t;
      return res;
   endfunction

   function automatic logic signed [CMP_BITS-1:0] ext_high(input logic [WIN_BITS-1:0] w);
      logic signed [CMP_BITS-1:0] res;
      res = '0;
      res[WIN_BITS-1:0] = w;
      return res;
   endfunction

   // Sign-extend the low window into the compare width
   function automatic logic signed [CMP_BITS-1:0] ext_low(input logic [WIN_BITS-1:0] w);
      logic signed [CMP_BITS-1:0] res;
      res = {CMP_BITS{w[WIN_BITS-1]}};
      res[WIN_BITS-1:0] = w;
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vchf_ram.sv =====
// Generic single-port RAM with registered read data.
// Self-contained; used for the veto time store.
`default_nettype none

module vchf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire                                        clock,
   input  wire                                        wr_en,
   input  wire                                        rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire [WIDTH-1:0]                            wr_data,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read on the shared port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/vchf_window_cmp.sv =====
// Shared window compare unit: registers dt = target - veto, then checks it
// against the low and high windows. Depends on vchf_pkg.
`default_nettype none

module vchf_window_cmp (
   input  wire                                 clock,
   input  wire                                 load,
   input  wire  [vchf_pkg::STORE_BITS-1:0]     target_time,
   input  wire  [vchf_pkg::STORE_BITS-1:0]     veto_time,
   input  wire  [vchf_pkg::WIN_BITS-1:0]       window_low,
   input  wire  [vchf_pkg::WIN_BITS-1:0]       window_high,
   output vchf_pkg::cmp_flags_type             flags
);

   logic signed [vchf_pkg::CMP_BITS-1:0] dt_ff;
   logic signed [vchf_pkg::CMP_BITS-1:0] dt_in;
   logic signed [vchf_pkg::CMP_BITS-1:0] low_ext;
   logic signed [vchf_pkg::CMP_BITS-1:0] high_ext;

   // Form the signed time difference
   assign dt_in = vchf_pkg::ext_time(target_time) - vchf_pkg::ext_time(veto_time);

   always_ff @(posedge clock) begin
      if (load) begin
         dt_ff <= dt_in;
      end
   end

   // Compare the held difference against both windows
   assign low_ext  = vchf_pkg::ext_low(window_low);
   assign high_ext = vchf_pkg::ext_high(window_high);

   always_comb begin
      flags.below_low = (dt_ff < low_ext);
      flags.in_window = !flags.below_low && (dt_ff < high_ext);
   end

endmodule

`default_nettype wire

// ===== rtl/veto_coincidence_hit_filter_core.sv =====
// Top level of the veto coincidence hit filter: request handling, scan
// sequencer and result register. Depends on vchf_pkg, vchf_ram, vchf_window_cmp.
//
//   Port group  Dir  Handshake           Payload
//   req_        in   req_valid/ready     req_payload_type (req_type, hit_time)
//   rsp_        out  rsp_valid/ready     rsp_payload_type (keep_hit, target_time,
//                                        store_overflow)
//   csr_        in   csr_we              csr_index, csr_wdata (window registers)
//
// Clear and load requests complete in the cycle they are accepted.
// A test request scans one entry per cycle until an entry lies below or inside the
// window or all entries are read; the result then waits while the result register
// is full. The scan uses the single RAM port and the two-stage compare pipeline.
// Synchronous reset clears count, overflow flag and control state, presets windows.
// req_ready is low while a test scan runs or its result waits to be loaded.
`default_nettype none

module veto_coincidence_hit_filter_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  vchf_pkg::req_payload_type            req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output vchf_pkg::rsp_payload_type            rsp_data,
   input  wire                                  csr_we,
   input  wire                                  csr_index,
   input  wire  [vchf_pkg::WIN_BITS-1:0]        csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [vchf_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic                                overflow_ff, overflow_in;
   logic [vchf_pkg::WIN_BITS-1:0]       win_low_ff, win_low_in;
   logic [vchf_pkg::WIN_BITS-1:0]       win_high_ff, win_high_in;
   logic [vchf_pkg::STORE_BITS-1:0]     target_ff, target_in;
   logic [vchf_pkg::COUNT_BITS-1:0]     issue_addr_ff, issue_addr_in;
   logic                                rd_valid_ff, rd_valid_in;
   logic                                dt_valid_ff, dt_valid_in;
   logic                                keep_ff, keep_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   vchf_pkg::rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                                req_fire;
   logic                                load_req;
   logic                                store_full;
   logic                                ram_wr_en;
   logic [vchf_pkg::ADDR_BITS-1:0]      ram_addr;
   logic [vchf_pkg::STORE_BITS-1:0]     ram_rd_data;
   logic                                issue_go;
   logic                                stop_hit;
   logic                                drain_done;
   logic                                out_fire;
   vchf_pkg::cmp_flags_type             flags;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign load_req   = req_fire && (req_data.req_type == vchf_pkg::REQ_LOAD);
   assign store_full = (count_ff == vchf_pkg::DEPTH_COUNT);
   assign ram_wr_en  = load_req && !store_full;

   // Scan control: issue reads, stop on a window decision or when drained
   assign issue_go   = (state_ff == S_SCAN) && (issue_addr_ff < count_ff) && !stop_hit;
   assign stop_hit   = (state_ff == S_SCAN) && dt_valid_ff &&
                       (flags.below_low || flags.in_window);
   assign drain_done = (state_ff == S_SCAN) && !(issue_addr_ff < count_ff) &&
                       !rd_valid_ff && !dt_valid_ff;
   assign out_fire   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   assign ram_addr = (state_ff == S_SCAN) ? issue_addr_ff[vchf_pkg::ADDR_BITS-1:0]
                                          : count_ff[vchf_pkg::ADDR_BITS-1:0];

   vchf_ram #(
      .WIDTH (vchf_pkg::STORE_BITS),
      .DEPTH (vchf_pkg::VETO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (issue_go),
      .addr    (ram_addr),
      .wr_data (req_data.hit_time[vchf_pkg::STORE_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   vchf_window_cmp u_cmp (
      .clock       (clock),
      .load        (rd_valid_ff),
      .target_time (target_ff),
      .veto_time   (ram_rd_data),
      .window_low  (win_low_ff),
      .window_high (win_high_ff),
      .flags       (flags)
   );

   // Next-state logic for requests, scan and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      win_low_in    = win_low_ff;
      win_high_in   = win_high_ff;
      target_in     = target_ff;
      issue_addr_in = issue_addr_ff;
      keep_in       = keep_ff;
      rd_valid_in   = issue_go;
      dt_valid_in   = rd_valid_ff && (state_ff == S_SCAN) && !stop_hit;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      // Write window registers
      if (csr_we) begin
         unique case (csr_index)
            vchf_pkg::CSR_WINDOW_LOW:  win_low_in  = csr_wdata;
            vchf_pkg::CSR_WINDOW_HIGH: win_high_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.req_type)
                  vchf_pkg::REQ_CLEAR: begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  vchf_pkg::REQ_LOAD: begin
                     if (store_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  vchf_pkg::REQ_TEST: begin
                     target_in     = req_data.hit_time[vchf_pkg::STORE_BITS-1:0];
                     issue_addr_in = '0;
                     state_in      = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (issue_go) begin
               issue_addr_in = issue_addr_ff + 1'b1;
            end
            if (stop_hit) begin
               keep_in  = flags.below_low;
               state_in = S_OUT;
            end else if (drain_done) begin
               keep_in  = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_fire) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.keep_hit       = keep_ff;
               rsp_data_in.target_time    = vchf_pkg::widen_time(target_ff);
               rsp_data_in.store_overflow = overflow_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         win_low_ff   <= vchf_pkg::WINDOW_LOW_RESET;
         win_high_ff  <= vchf_pkg::WINDOW_HIGH_RESET;
         rd_valid_ff  <= 1'b0;
         dt_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         rd_valid_ff  <= rd_valid_in;
         dt_valid_ff  <= dt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      issue_addr_ff <= issue_addr_in;
      keep_ff       <= keep_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vchf_pkg::DEPTH_COUNT)
      else $error("veto count exceeds store depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_addr_ff <= count_ff))
      else $error("scan address ran past veto count");

   a_test_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.req_type == vchf_pkg::REQ_TEST)) |=> (state_ff == S_SCAN))
      else $error("test request did not start a scan");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      dt_valid_ff |-> (state_ff == S_SCAN))
      else $error("compare stage live outside a scan");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised without a finished scan");
`endif

endmodule

`default_nettype wire

// ===== tb/veto_coincidence_hit_filter_core_tb.sv =====
// Self-checking bench for the veto coincidence hit filter core: clear, load and
// test requests with random handshake gaps, checked against an in-bench scan of
// the veto store. Depends on vchf_pkg and the core RTL.
module veto_coincidence_hit_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_IGNORED     = 2'd3;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         SETTLE_CYCLES   = vchf_pkg::VETO_DEPTH + 16;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam longint     WIN_LOW_MIN     = -(longint'(1) << (vchf_pkg::WIN_BITS - 1));
   localparam longint     WIN_HIGH_MAX    = longint'(1) << (vchf_pkg::WIN_BITS - 1);

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   vchf_pkg::req_payload_type           req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   vchf_pkg::rsp_payload_type           rsp_data;
   logic                                csr_we    = 1'b0;
   logic                                csr_index = 1'b0;
   logic [vchf_pkg::WIN_BITS-1:0]       csr_wdata = '0;

   // Mirror of the block state and window registers
   logic [vchf_pkg::HIT_BITS-1:0]        veto_mirror [vchf_pkg::VETO_DEPTH];
   int                                   veto_fill       = 0;
   bit                                   overflow_mirror = 1'b0;
   logic signed [vchf_pkg::WIN_BITS-1:0] win_low_q       = vchf_pkg::WINDOW_LOW_RESET;
   logic [vchf_pkg::WIN_BITS-1:0]        win_high_q      = vchf_pkg::WINDOW_HIGH_RESET;

   vchf_pkg::req_payload_type       request_backlog [$];
   vchf_pkg::rsp_payload_type       verdict_queue [$];
   logic [vchf_pkg::HIT_BITS-1:0]   loaded_times [$];

   int     sent_count  = 0;
   int     result_count = 0;
   int     error_count = 0;
   int     clear_sent  = 0;
   int     load_sent   = 0;
   int     test_sent   = 0;
   int     veto_seen   = 0;
   int     flagged_seen = 0;
   int     hold_left   = 0;
   bit     hold_done   = 1'b0;
   longint cycle_count = 0;
   logic   steady_in;
   logic   steady_out;

   assign steady_in  = (sent_count >= 250) && (sent_count < 400);
   assign steady_out = (result_count >= 80) && (result_count < 160);

   veto_coincidence_hit_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Apply one accepted request to the mirror and queue its verdict
   function automatic void predict_verdict(input vchf_pkg::req_payload_type r);
      vchf_pkg::rsp_payload_type v;
      longint          dt;
      longint          lo;
      longint          hi;
      bit              keep;
      keep = 1'b1;
      case (r.req_type)
         vchf_pkg::REQ_CLEAR: begin
            veto_fill       = 0;
            overflow_mirror = 1'b0;
         end
         vchf_pkg::REQ_LOAD: begin
            if (veto_fill < vchf_pkg::VETO_DEPTH) begin
               veto_mirror[veto_fill] = r.hit_time;
               veto_fill++;
            end else begin
               overflow_mirror = 1'b1;
            end
         end
         vchf_pkg::REQ_TEST: begin
            lo = longint'(win_low_q);
            hi = longint'({1'b0, win_high_q});
            // Scan in load order; the first entry below or inside the window decides
            for (int k = 0; k < veto_fill; k++) begin
               dt = longint'({16'd0, r.hit_time}) - longint'({16'd0, veto_mirror[k]});
               if (dt < lo) break;
               if (dt < hi) begin
                  keep = 1'b0;
                  break;
               end
            end
            v.keep_hit       = keep;
            v.target_time    = r.hit_time;
            v.store_overflow = overflow_mirror;
            verdict_queue.push_back(v);
         end
         default: ;
      endcase
   endfunction

   function automatic logic [vchf_pkg::HIT_BITS-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[vchf_pkg::HIT_BITS-1:0];
   endfunction

   // Queue a request and track which times the store will hold
   function automatic void queue_request(input logic [1:0] kind,
                                         input logic [vchf_pkg::HIT_BITS-1:0] t);
      vchf_pkg::req_payload_type r;
      r.req_type = kind;
      r.hit_time = t;
      request_backlog.push_back(r);
      if (kind == vchf_pkg::REQ_CLEAR)
         loaded_times.delete();
      else if (kind == vchf_pkg::REQ_LOAD && loaded_times.size() < vchf_pkg::VETO_DEPTH)
         loaded_times.push_back(t);
   endfunction

   // Time difference aimed at the window edges, its inside, or anywhere
   function automatic longint pick_offset();
      longint      lo;
      longint      hi;
      logic [63:0] w;
      lo = longint'(win_low_q);
      hi = longint'({1'b0, win_high_q});
      w  = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return lo - 1;
         1: return lo;
         2: return hi - 1;
         3: return hi;
         4: return 0;
         5: return longint'($signed(w[vchf_pkg::HIT_BITS:0]));
         default: return lo + (longint'(w >> 1) % (hi - lo + 1));
      endcase
   endfunction

   function automatic logic [vchf_pkg::HIT_BITS-1:0] near_time(
      input logic [vchf_pkg::HIT_BITS-1:0] anchor);
      logic [63:0] s;
      s = longint'({16'd0, anchor}) + pick_offset();
      return s[vchf_pkg::HIT_BITS-1:0];
   endfunction

   // One random burst: a fresh store, a few appends, a test, or noise
   function automatic void queue_burst(inout int counted);
      int                            pick;
      int                            n;
      logic [1:0]                    kind;
      logic [vchf_pkg::HIT_BITS-1:0] anchor;
      pick = $urandom_range(0, 99);
      if (loaded_times.size() > 0)
         anchor = loaded_times[$urandom_range(0, loaded_times.size() - 1)];
      else
         anchor = rand_time();
      if (pick < 8) begin
         n = ($urandom_range(0, 9) == 0)
             ? $urandom_range(vchf_pkg::VETO_DEPTH - 4, vchf_pkg::VETO_DEPTH + 6)
             : $urandom_range(0, 8);
         queue_request(vchf_pkg::REQ_CLEAR, rand_time());
         anchor = rand_time();
         for (int i = 0; i < n; i++) queue_request(vchf_pkg::REQ_LOAD, near_time(anchor));
         counted += n + 1;
      end else if (pick < 14) begin
         kind = 2'($urandom_range(0, 3));
         queue_request(kind, rand_time());
         if (kind != REQ_IGNORED) counted++;
      end else if (pick < 34) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) queue_request(vchf_pkg::REQ_LOAD, near_time(anchor));
         counted += n;
      end else begin
         queue_request(vchf_pkg::REQ_TEST, near_time(anchor));
         counted++;
      end
   endfunction

   // Edge cases under the reset windows
   function automatic void queue_directed();
      logic [vchf_pkg::HIT_BITS-1:0] top_time;
      top_time = '1;
      queue_request(vchf_pkg::REQ_TEST, '0);
      queue_request(vchf_pkg::REQ_TEST, top_time);
      queue_request(REQ_IGNORED, top_time);
      queue_request(vchf_pkg::REQ_LOAD, '0);
      queue_request(vchf_pkg::REQ_LOAD, top_time);
      queue_request(vchf_pkg::REQ_TEST, '0);
      queue_request(vchf_pkg::REQ_TEST, 48'd79999);
      queue_request(vchf_pkg::REQ_TEST, 48'd80000);
      queue_request(vchf_pkg::REQ_TEST, top_time);
      queue_request(vchf_pkg::REQ_CLEAR, top_time);
      queue_request(vchf_pkg::REQ_TEST, 48'd5);
      queue_request(vchf_pkg::REQ_LOAD, 48'd1000000);
      queue_request(vchf_pkg::REQ_TEST, 48'd920000);
      queue_request(vchf_pkg::REQ_TEST, 48'd919999);
      queue_request(vchf_pkg::REQ_LOAD, '0);
      queue_request(vchf_pkg::REQ_TEST, 48'd1080000);
      queue_request(REQ_IGNORED, '0);
      queue_request(vchf_pkg::REQ_TEST, 48'd1079999);
      queue_request(vchf_pkg::REQ_CLEAR, '0);
   endfunction

   // Hold until every request is taken and every verdict is back; sample
   // between edges so the driver and monitor have settled
   task automatic wait_idle();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic idx, input logic [vchf_pkg::WIN_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == vchf_pkg::CSR_WINDOW_LOW)
         win_low_q = value;
      else
         win_high_q = value;
   endtask

   task automatic run_phase(input longint lo, input longint hi, input int items);
      int counted;
      counted = 0;
      wait_idle();
      write_window(vchf_pkg::CSR_WINDOW_LOW, lo[vchf_pkg::WIN_BITS-1:0]);
      write_window(vchf_pkg::CSR_WINDOW_HIGH, hi[vchf_pkg::WIN_BITS-1:0]);
      while (counted < items) queue_burst(counted);
   endtask

   // Request driver: take from the backlog, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_verdict(req_data);
            sent_count++;
            case (req_data.req_type)
               vchf_pkg::REQ_CLEAR: clear_sent++;
               vchf_pkg::REQ_LOAD:  load_sent++;
               vchf_pkg::REQ_TEST:  test_sent++;
               default: ;
            endcase
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && (steady_in || $urandom_range(0, 99) >= 25)) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Verdict monitor: compare with the oldest prediction, stall at random
   always @(posedge clock) begin
      vchf_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (!rsp_data.keep_hit) veto_seen++;
            if (rsp_data.store_overflow) flagged_seen++;
            if (verdict_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected verdict: keep=%0b time=%h overflow=%0b",
                           rsp_data.keep_hit, rsp_data.target_time, rsp_data.store_overflow);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data.keep_hit !== want.keep_hit ||
                   rsp_data.target_time !== want.target_time ||
                   rsp_data.store_overflow !== want.store_overflow) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("verdict %0d mismatch: ", result_count,
                              "expected keep=%0b time=%h overflow=%0b, ",
                              want.keep_hit, want.target_time, want.store_overflow,
                              "got keep=%0b time=%h overflow=%0b",
                              rsp_data.keep_hit, rsp_data.target_time,
                              rsp_data.store_overflow);
               end
            end
         end
         // Hold off once for a long stretch so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && result_count >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_out || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d verdicts outstanding",
                  verdict_queue.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      run_phase(-80000, 80000, 100);
      run_phase(-50, 50, 100);
      run_phase(WIN_LOW_MIN, WIN_HIGH_MAX, 90);
      run_phase(0, 0, 80);
      run_phase(-1, 1, 80);
      run_phase(-longint'($urandom_range(0, 1 << 20)), longint'($urandom_range(0, 1 << 20)), 100);
      run_phase(-80000, 80000, 80);
      wait_idle();
      $display("sent %0d clears, %0d loads, %0d tests across seven window settings",
               clear_sent, load_sent, test_sent);
      $display("checked %0d verdicts: %0d vetoed, %0d with store overflow, %0d mismatches",
               result_count, veto_seen, flagged_seen, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/vchf_pkg.sv
rtl/vchf_ram.sv
rtl/vchf_window_cmp.sv
rtl/veto_coincidence_hit_filter_core.sv
tb/veto_coincidence_hit_filter_core_tb.sv
